@@ src/aabb_frustum_cull_assert.svh @@
// Assertion macros for the box culling block.
// Included by the top level; needs clk and rst in the including scope.
`ifndef AABB_FRUSTUM_CULL_ASSERT_SVH
`define AABB_FRUSTUM_CULL_ASSERT_SVH
`ifndef ASSERT_OFF
`define AFC_ASSERT_IMPLIES(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
`define AFC_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`else
`define AFC_ASSERT_IMPLIES(label, lhs, rhs, msg)
`define AFC_ASSERT_NEXT(label, lhs, rhs, msg)
`endif
`endif

@@ src/afc_pkg.sv @@
// Shared constants, types and operation codes of the box culling block.
// No dependencies.
`default_nettype none
package afc_pkg;
  localparam int AFC_FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int HALF_W = 31;
  localparam int ROWS = 4;
  localparam int AXES = 3;
  localparam int CORNERS = 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [HALF_W-1:0] half_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef struct packed {
    logic       en;
    logic       valid;
    logic       op;
    logic [1:0] row;
  } afc_ctl_t;
endpackage
`default_nettype wire

@@ src/afc_if.sv @@
// Valid/ready channel interfaces for the request and result streams.
// Depends on afc_pkg.
`default_nettype none
interface afc_req_if import afc_pkg::*;;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [1:0] row_index;
  coord_t     row_col0;
  coord_t     row_col1;
  coord_t     row_col2;
  coord_t     row_col3;
  coord_t     center_x;
  coord_t     center_y;
  coord_t     center_z;
  half_t      half_x;
  half_t      half_y;
  half_t      half_z;

  modport source (output valid, operation, row_index, row_col0, row_col1, row_col2,
                  row_col3, center_x, center_y, center_z, half_x, half_y, half_z,
                  input ready);
  modport sink (input valid, operation, row_index, row_col0, row_col1, row_col2,
                row_col3, center_x, center_y, center_z, half_x, half_y, half_z,
                output ready);
endinterface

interface afc_rsp_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

@@ src/afc_xform.sv @@
// Matrix store and the multiply and sum stages that give clip coordinates.
// Depends on afc_pkg.
`default_nettype none
module afc_xform import afc_pkg::*; #(
  parameter int FRAC_BITS = AFC_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  afc_ctl_t ctl,
  input  coord_t   col [ROWS],
  input  coord_t   p [AXES][2],
  output coord_t   clip [CORNERS][ROWS],
  output logic     clip_valid
);
  localparam int TERM_W = 2 * COORD_W - FRAC_BITS;
  localparam int SUM_W = TERM_W + 2;

  coord_t                     m [ROWS][ROWS];
  logic signed [2*COORD_W-1:0] prod [ROWS][AXES][2];
  coord_t                     m3 [ROWS];
  logic                       v2;
  logic signed [SUM_W-1:0]    pair01 [ROWS][2][2];
  logic signed [SUM_W-1:0]    pair2m [ROWS][2];
  logic                       v3;
  logic signed [TERM_W-1:0]   term [ROWS][AXES][2];
  logic signed [SUM_W-1:0]    total [CORNERS][ROWS];
  coord_t                     clip_next [CORNERS][ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < ROWS; c++) begin
          m[r][c] <= '0;
        end
      end
    end else if (ctl.en && ctl.valid && ctl.op == OP_LOAD) begin
      m[ctl.row] <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      clip_valid <= 1'b0;
    end else if (ctl.en) begin
      v2 <= ctl.valid && ctl.op == OP_TEST;
      v3 <= v2;
      clip_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int r = 0; r < ROWS; r++) begin
        m3[r] <= m[r][AXES];
        for (int c = 0; c < AXES; c++) begin
          for (int s = 0; s < 2; s++) begin
            prod[r][c][s] <= m[r][c] * p[c][s];
          end
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < AXES; c++) begin
        for (int s = 0; s < 2; s++) begin
          term[r][c][s] = TERM_W'(prod[r][c][s] >>> FRAC_BITS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int s0 = 0; s0 < 2; s0++) begin
          for (int s1 = 0; s1 < 2; s1++) begin
            pair01[r][s0][s1] <= SUM_W'(term[r][0][s0]) + SUM_W'(term[r][1][s1]);
          end
          pair2m[r][s0] <= SUM_W'(term[r][2][s0]) + SUM_W'(m3[r]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      for (int r = 0; r < ROWS; r++) begin
        total[k][r] = pair01[r][k%2][(k/2)%2] + pair2m[r][(k/4)%2];
        if ((&total[k][r][SUM_W-1:COORD_W-1]) || !(|total[k][r][SUM_W-1:COORD_W-1])) begin
          clip_next[k][r] = total[k][r][COORD_W-1:0];
        end else if (total[k][r][SUM_W-1]) begin
          clip_next[k][r] = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
          clip_next[k][r] = {1'b0, {(COORD_W-1){1'b1}}};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      clip <= clip_next;
    end
  end
endmodule
`default_nettype wire

@@ src/aabb_frustum_cull.sv @@
// Box culling against the clip cube. Tests pass the entry, product, pair sum,
// clip, compare and result registers. One item, load or test, is taken every
// cycle the result register is empty or taken; all stages advance together,
// so throughput is set by the result channel alone. Loads give no result.
// Reset (rst, synchronous) clears the matrix to zero and all stage valid bits.
`default_nettype none
`include "aabb_frustum_cull_assert.svh"
module aabb_frustum_cull import afc_pkg::*; #(
  parameter int FRAC_BITS = AFC_FRAC_BITS
) (
  input logic       clk,
  input logic       rst,
  afc_req_if.sink   req,
  afc_rsp_if.source rsp
);
  logic     en;
  logic     s1_valid;
  logic     s1_op;
  logic [1:0] s1_row;
  coord_t   s1_col [ROWS];
  coord_t   s1_p [AXES][2];
  coord_t   p_next [AXES][2];
  coord_t   ctr [AXES];
  half_t    half [AXES];
  logic signed [COORD_W:0] ext_sum [AXES][2];
  afc_ctl_t ctl;
  coord_t   clip [CORNERS][ROWS];
  logic     clip_valid;
  logic     s5_valid;
  logic [CORNERS-1:0] lt [AXES];
  logic [CORNERS-1:0] gt [AXES];
  logic [CORNERS-1:0] lt_next [AXES];
  logic [CORNERS-1:0] gt_next [AXES];
  logic signed [COORD_W:0] c_ext;
  logic signed [COORD_W:0] w_ext;
  logic signed [COORD_W:0] w_neg;
  logic     vis_next;

  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign ctr[0] = req.center_x;
  assign ctr[1] = req.center_y;
  assign ctr[2] = req.center_z;
  assign half[0] = req.half_x;
  assign half[1] = req.half_y;
  assign half[2] = req.half_z;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ext_sum[a][0] = (COORD_W+1)'(ctr[a]) + $signed({2'b00, half[a]});
      ext_sum[a][1] = (COORD_W+1)'(ctr[a]) - $signed({2'b00, half[a]});
      for (int s = 0; s < 2; s++) begin
        if (ext_sum[a][s][COORD_W] == ext_sum[a][s][COORD_W-1]) begin
          p_next[a][s] = ext_sum[a][s][COORD_W-1:0];
        end else if (ext_sum[a][s][COORD_W]) begin
          p_next[a][s] = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
          p_next[a][s] = {1'b0, {(COORD_W-1){1'b1}}};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= req.operation;
      s1_row <= req.row_index;
      s1_col[0] <= req.row_col0;
      s1_col[1] <= req.row_col1;
      s1_col[2] <= req.row_col2;
      s1_col[3] <= req.row_col3;
      s1_p <= p_next;
    end
  end

  assign ctl = '{en: en, valid: s1_valid, op: s1_op, row: s1_row};

  afc_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .col(s1_col),
    .p(s1_p),
    .clip(clip),
    .clip_valid(clip_valid)
  );

  // The quotient c/w is below +1 or above -1 exactly when these compares hold.
  always_comb begin
    c_ext = '0;
    w_ext = '0;
    w_neg = '0;
    for (int k = 0; k < CORNERS; k++) begin
      w_ext = (COORD_W+1)'(clip[k][AXES]);
      w_neg = -w_ext;
      for (int a = 0; a < AXES; a++) begin
        c_ext = (COORD_W+1)'(clip[k][a]);
        if (w_ext == '0) begin
          lt_next[a][k] = c_ext <= 0;
          gt_next[a][k] = c_ext >= 0;
        end else if (w_ext[COORD_W]) begin
          lt_next[a][k] = c_ext > w_ext;
          gt_next[a][k] = c_ext < w_neg;
        end else begin
          lt_next[a][k] = c_ext < w_ext;
          gt_next[a][k] = c_ext > w_neg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (en) begin
      s5_valid <= clip_valid;
      rsp.valid <= s5_valid;
    end
  end

  always_comb begin
    vis_next = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      vis_next = vis_next && (|lt[a]) && (|gt[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt <= lt_next;
      gt <= gt_next;
      rsp.visible <= vis_next;
    end
  end

  `AFC_ASSERT_IMPLIES(a_backpressure, rsp.valid && !rsp.ready, !req.ready, "stall not passed to input")
  `AFC_ASSERT_NEXT(a_accept, req.valid && req.ready, s1_valid, "accepted transfer lost at entry")
  `AFC_ASSERT_NEXT(a_drain, en && s5_valid, rsp.valid, "test result lost before output")
endmodule
`default_nettype wire
